/* sv/rmlm_pkg.sv */
// Shared types, codes and default sizes for the recursive mutex lock manager.
`timescale 1ns / 1ps

package rmlm_pkg;

  localparam int unsigned NUM_MUTEXES_DEF = 128;
  localparam int unsigned MAX_TASKS_DEF   = 64;
  localparam int unsigned DEPTH_W         = 32;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned STATUS_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_QUEUED = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic look;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } ctrl_stat_t;

endpackage

/* sv/rmlm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module rmlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/rmlm_ctrl.sv */
// Controller state machine: accept, table lookup, execute and commit.
`timescale 1ns / 1ps

module rmlm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  rmlm_pkg::ctrl_stat_t   stat_i,
  output rmlm_pkg::ctrl_cmd_t    cmd_o
);

  rmlm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmlm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmlm_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = rmlm_pkg::S_LOOKUP;
        end
      end
      rmlm_pkg::S_LOOKUP: begin
        state_d = rmlm_pkg::S_EXEC;
      end
      rmlm_pkg::S_EXEC: begin
        if (stat_i.out_free) begin
          state_d = rmlm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rmlm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      rmlm_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      rmlm_pkg::S_LOOKUP: begin
        cmd_o.look = 1'b1;
      end
      rmlm_pkg::S_EXEC: begin
        // The update is held back until the output register can take the result.
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/rmlm_dp.sv */
// Datapath: request registers, mutex table, waiter rings and result register.
`timescale 1ns / 1ps

module rmlm_dp #(
  parameter int unsigned NUM_MUTEXES = rmlm_pkg::NUM_MUTEXES_DEF,
  parameter int unsigned MAX_TASKS   = rmlm_pkg::MAX_TASKS_DEF,
  localparam int unsigned MW       = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1,
  localparam int unsigned TW       = $clog2(MAX_TASKS),
  localparam int unsigned IN_W     = MW + TW,
  localparam int unsigned IN_BITS  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W    = rmlm_pkg::STATUS_W + MW + 1 + TW,
  localparam int unsigned OUT_BITS = ((OUT_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmlm_pkg::ctrl_cmd_t         cmd_i,
  output rmlm_pkg::ctrl_stat_t        stat_o,
  input  logic [IN_BITS-1:0]          s_axis_tdata,
  input  logic [rmlm_pkg::OP_W-1:0]   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OUT_BITS-1:0]         m_axis_tdata
);

  localparam int unsigned CW    = $clog2(MAX_TASKS + 1);
  localparam int unsigned SW    = TW + 1;
  localparam int unsigned CTW   = $clog2(NUM_MUTEXES + 1);
  localparam int unsigned DW    = rmlm_pkg::DEPTH_W;
  localparam int unsigned WDEP  = NUM_MUTEXES * MAX_TASKS;
  localparam int unsigned WAW   = $clog2(WDEP);

  typedef struct packed {
    logic          held;
    logic [TW-1:0] owner;
    logic [DW-1:0] depth;
    logic [TW-1:0] head;
    logic [CW-1:0] total;
  } rec_t;

  localparam int unsigned RW = $bits(rec_t);

  logic [rmlm_pkg::OP_W-1:0] req_op_q;
  logic [MW-1:0]             req_m_q;
  logic [TW-1:0]             req_pid_q;
  logic [CTW-1:0]            cnt_q, cnt_d;
  logic                      out_valid_q;
  logic [OUT_W-1:0]          out_q, out_d;

  logic [RW-1:0]  mrec_rdata;
  rec_t           rec_rd, rec_wr;
  logic           rec_we;
  logic [MW-1:0]  rec_waddr;
  logic [TW-1:0]  wtask_rdata;
  logic           wq_we;
  logic [WAW-1:0] wq_waddr;
  logic [WAW-1:0] wq_raddr;
  logic [WAW-1:0] ring_base;
  logic [SW-1:0]  tail_sum;
  logic [SW-1:0]  tail_slot;
  logic [SW-1:0]  head_inc;
  logic [DW-1:0]  depth_dec;
  logic           m_known;

  logic [rmlm_pkg::STATUS_W-1:0] status;
  logic [MW-1:0]                 created_id;
  logic                          handoff_valid;
  logic [TW-1:0]                 new_owner;

  // Request capture on the accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_op_q  <= s_axis_tuser;
      req_m_q   <= s_axis_tdata[MW-1:0];
      req_pid_q <= s_axis_tdata[IN_W-1:MW];
    end
  end

  rmlm_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_MUTEXES)
  ) u_mutex_ram (
    .clk_i     (clk_i),
    .wr_en_i   (rec_we),
    .wr_addr_i (rec_waddr),
    .wr_data_i (rec_wr),
    .rd_en_i   (cmd_i.capture),
    .rd_addr_i (s_axis_tdata[MW-1:0]),
    .rd_data_o (mrec_rdata)
  );

  assign rec_rd = rec_t'(mrec_rdata);

  // Each mutex owns a ring of MAX_TASKS slots in the waiter store.
  assign ring_base = WAW'(WAW'(req_m_q) * WAW'(MAX_TASKS));
  assign wq_raddr  = WAW'(ring_base + WAW'(rec_rd.head));

  assign tail_sum  = SW'(rec_rd.head) + SW'(rec_rd.total);
  assign tail_slot = (tail_sum >= SW'(MAX_TASKS)) ? SW'(tail_sum - SW'(MAX_TASKS)) : tail_sum;
  assign wq_waddr  = WAW'(ring_base + WAW'(tail_slot));
  assign head_inc  = SW'(rec_rd.head) + SW'(1);
  assign depth_dec = rec_rd.depth - DW'(1);

  rmlm_ram #(
    .WIDTH (TW),
    .DEPTH (WDEP)
  ) u_waiter_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wq_we),
    .wr_addr_i (wq_waddr),
    .wr_data_i (req_pid_q),
    .rd_en_i   (cmd_i.look),
    .rd_addr_i (wq_raddr),
    .rd_data_o (wtask_rdata)
  );

  assign m_known = (CTW'(req_m_q) < cnt_q);

  always_comb begin
    rec_wr        = rec_rd;
    rec_we        = 1'b0;
    rec_waddr     = req_m_q;
    wq_we         = 1'b0;
    cnt_d         = cnt_q;
    status        = rmlm_pkg::ST_ERROR;
    created_id    = '0;
    handoff_valid = 1'b0;
    new_owner     = '0;
    case (req_op_q)
      rmlm_pkg::OP_CREATE: begin
        if (cnt_q != CTW'(NUM_MUTEXES)) begin
          rec_we     = 1'b1;
          rec_waddr  = cnt_q[MW-1:0];
          rec_wr     = '0;
          cnt_d      = cnt_q + CTW'(1);
          created_id = cnt_q[MW-1:0];
          status     = rmlm_pkg::ST_DONE;
        end
      end
      rmlm_pkg::OP_LOCK: begin
        if (m_known) begin
          if (!rec_rd.held || rec_rd.owner == req_pid_q) begin
            rec_we       = 1'b1;
            rec_wr.held  = 1'b1;
            rec_wr.owner = req_pid_q;
            rec_wr.depth = rec_rd.depth + DW'(1);
            status       = rmlm_pkg::ST_DONE;
          end else if (rec_rd.total != CW'(MAX_TASKS)) begin
            rec_we       = 1'b1;
            wq_we        = 1'b1;
            rec_wr.total = rec_rd.total + CW'(1);
            status       = rmlm_pkg::ST_QUEUED;
          end
        end
      end
      rmlm_pkg::OP_UNLOCK: begin
        if (m_known && rec_rd.held && rec_rd.owner == req_pid_q) begin
          rec_we       = 1'b1;
          rec_wr.depth = depth_dec;
          status       = rmlm_pkg::ST_DONE;
          if (depth_dec == '0) begin
            if (rec_rd.total != '0) begin
              // Ownership passes to the oldest waiter with a count of one.
              rec_wr.owner  = wtask_rdata;
              rec_wr.depth  = DW'(1);
              rec_wr.head   = (head_inc == SW'(MAX_TASKS)) ? '0 : head_inc[TW-1:0];
              rec_wr.total  = rec_rd.total - CW'(1);
              handoff_valid = 1'b1;
              new_owner     = wtask_rdata;
            end else begin
              rec_wr.held = 1'b0;
            end
          end
        end
      end
      default: begin
        status = rmlm_pkg::ST_ERROR;
      end
    endcase
    if (!cmd_i.commit) begin
      rec_we = 1'b0;
      wq_we  = 1'b0;
      cnt_d  = cnt_q;
    end
  end

  assign out_d = {new_owner, handoff_valid, created_id, status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = OUT_BITS'(out_q);

endmodule

/* sv/recursive_mutex_lock_manager.sv */
// Top level of the recursive mutex lock manager.
//
// Input stream: one beat per request. tuser carries the opcode (create, lock,
// unlock); tdata carries the mutex number and the task number. Output stream:
// one beat per request with status, created mutex number, handoff flag and the
// new owner on handoff.
// A request is handled in order: the mutex record is read from its RAM, the
// oldest waiter is read from the waiter RAM, and both are updated while the
// result register is loaded. A new request is not taken until the one before
// it has made its update. The result beat becomes valid when the update loads
// the result register.
// The result register sits between the two sides: while it holds a result the
// next request can still be accepted and looked up; only the final update waits
// until the receiver takes the pending beat.
// Reset clears the control state and the count of created mutexes, so all
// operations on mutexes error until they are created. The tables need no
// clearing pass; a record is initialized when its mutex is created.
`timescale 1ns / 1ps

module recursive_mutex_lock_manager #(
  parameter int unsigned NUM_MUTEXES = rmlm_pkg::NUM_MUTEXES_DEF,
  parameter int unsigned MAX_TASKS   = rmlm_pkg::MAX_TASKS_DEF,
  localparam int unsigned MW       = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1,
  localparam int unsigned TW       = $clog2(MAX_TASKS),
  localparam int unsigned IN_W     = MW + TW,
  localparam int unsigned IN_BITS  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W    = rmlm_pkg::STATUS_W + MW + 1 + TW,
  localparam int unsigned OUT_BITS = ((OUT_W + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_BITS-1:0]        s_axis_tdata,  // mutex number, pid, zero fill
  input  logic [rmlm_pkg::OP_W-1:0] s_axis_tuser,  // opcode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_BITS-1:0]       m_axis_tdata   // status, created_id, handoff_valid,
                                                   // new_owner, zero fill
);

  rmlm_pkg::ctrl_cmd_t  cmd;
  rmlm_pkg::ctrl_stat_t stat;

  rmlm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  rmlm_dp #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .MAX_TASKS   (MAX_TASKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* sv/rmlm_checker.sv */
// Port-level checker for the lock manager and its bind to the top level.
`timescale 1ns / 1ps

module rmlm_checker #(
  parameter int unsigned NUM_MUTEXES = rmlm_pkg::NUM_MUTEXES_DEF,
  parameter int unsigned MAX_TASKS   = rmlm_pkg::MAX_TASKS_DEF,
  localparam int unsigned MW       = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1,
  localparam int unsigned TW       = $clog2(MAX_TASKS),
  localparam int unsigned OUT_W    = rmlm_pkg::STATUS_W + MW + 1 + TW,
  localparam int unsigned OUT_BITS = ((OUT_W + 7) / 8) * 8,
  localparam int unsigned HV_POS   = rmlm_pkg::STATUS_W + MW
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_BITS-1:0]       m_axis_tdata
);

  logic [rmlm_pkg::STATUS_W-1:0] st;
  logic                          hv;
  logic [TW-1:0]                 nown;

  assign st   = m_axis_tdata[rmlm_pkg::STATUS_W-1:0];
  assign hv   = m_axis_tdata[HV_POS];
  assign nown = m_axis_tdata[HV_POS+TW:HV_POS+1];

  // A request occupies the block for its lookup and update cycles.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request accepted during lookup or update");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_handoff_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && hv |-> st == rmlm_pkg::ST_DONE)
    else $error("handoff reported without a completed unlock");

  a_owner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hv |-> nown == '0)
    else $error("new owner set without a handoff");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == rmlm_pkg::ST_ERROR |-> !hv && m_axis_tdata[HV_POS-1:0] ==
      HV_POS'(rmlm_pkg::ST_ERROR))
    else $error("error result carries extra fields");

endmodule

bind recursive_mutex_lock_manager rmlm_checker #(
  .NUM_MUTEXES (NUM_MUTEXES),
  .MAX_TASKS   (MAX_TASKS)
) u_rmlm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
